@@ rtl/hpc_pkg.sv @@
// package: word types, request codes and constants for the half precision converter
`default_nettype none
package hpc_pkg;

  typedef enum logic [1:0] {
    REQ_SINT_TO_HALF = 2'd0,
    REQ_UINT_TO_HALF = 2'd1,
    REQ_SINGLE_TO_HALF = 2'd2,
    REQ_HALF_TO_SINGLE = 2'd3
  } req_type_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] operand_bits;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        saturated;
  } out_word_t;

  localparam logic [15:0] HALF_SIGN = 16'h8000;
  localparam logic [15:0] HALF_FRAC_MASK = 16'h03ff;
  localparam logic [15:0] HALF_INF = 16'h7c00;
  localparam logic [4:0]  HALF_EXP_MAX = 5'h1f;
  localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;
  localparam logic [31:0] SINGLE_FRAC_MASK = 32'h007fffff;
  localparam logic [7:0]  DENORM_BIAS = 8'd90;
  localparam int unsigned PIPE_DEPTH = 3;

endpackage
`default_nettype wire

@@ rtl/half_precision_converter.sv @@
// top level: three-stage pipelined conversion between integer, single and half
// a started word passes the stage 1, 2 and 3 registers in turn; out_valid is stage 3's bit
// throughput: one word every cycle; busy is tied low, as the three-stage datapath never stalls
// reset: synchronous active-low rst_n clears the stage valid bits only
// the receiver cannot stall; each result shows for exactly one cycle
`default_nettype none
module half_precision_converter import hpc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  output out_word_t      out_word
);

  // stage 1: operand magnitude
  logic        v1_r;
  logic [1:0]  kind1_r;
  logic [31:0] op1_r;
  logic [31:0] mag1_r;
  logic        neg1_r;
  logic [31:0] mag1_nxt;
  logic        neg1_nxt;

  assign busy = 1'b0;

  always_comb begin
    neg1_nxt = 1'b0;
    mag1_nxt = in_word.operand_bits;
    unique case (req_type_t'(in_word.req_type))
      REQ_SINT_TO_HALF: begin
        neg1_nxt = in_word.operand_bits[31];
        if (in_word.operand_bits[31]) mag1_nxt = 32'd0 - in_word.operand_bits;
      end
      REQ_UINT_TO_HALF: mag1_nxt = in_word.operand_bits;
      REQ_SINGLE_TO_HALF: mag1_nxt = in_word.operand_bits;
      REQ_HALF_TO_SINGLE: mag1_nxt = {22'd0, in_word.operand_bits[9:0]};
      default: mag1_nxt = in_word.operand_bits;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    kind1_r <= in_word.req_type;
    op1_r <= in_word.operand_bits;
    mag1_r <= mag1_nxt;
    neg1_r <= neg1_nxt;
  end

  // stage 2: leading-one detect
  logic        found;
  logic [4:0]  pos;
  logic        v2_r;
  logic [1:0]  kind2_r;
  logic [31:0] op2_r;
  logic [31:0] mag2_r;
  logic        neg2_r;
  logic        found2_r;
  logic [4:0]  pos2_r;

  hpc_lzd u_lzd (
    .value(mag1_r),
    .found(found),
    .pos(pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    kind2_r <= kind1_r;
    op2_r <= op1_r;
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
    found2_r <= found;
    pos2_r <= pos;
  end

  // stage 3: shift and pack
  logic        v3_r;
  out_word_t   res3_r;
  out_word_t   res3_nxt;
  logic [15:0] hsgn;
  logic [7:0]  ef;
  logic [31:0] full;
  logic [5:0]  sh;
  logic [4:0]  hef;
  logic [31:0] fsh;

  always_comb begin
    res3_nxt = '0;
    hsgn = 16'd0;
    ef = op2_r[30:23];
    full = (op2_r & SINGLE_FRAC_MASK) | 32'h00800000;
    sh = 6'd0;
    hef = op2_r[14:10];
    fsh = 32'd0;
    unique case (req_type_t'(kind2_r))
      REQ_SINT_TO_HALF, REQ_UINT_TO_HALF: begin
        hsgn = neg2_r ? HALF_SIGN : 16'd0;
        if (!found2_r) begin
          res3_nxt.result_bits = 32'd0;
        end else if (pos2_r >= 5'd16) begin
          res3_nxt.result_bits = {16'd0, hsgn | HALF_INF};
          res3_nxt.saturated = 1'b1;
        end else begin
          if (pos2_r <= 5'd10) fsh = mag2_r << (5'd10 - pos2_r);
          else fsh = mag2_r >> (pos2_r - 5'd10);
          res3_nxt.result_bits = {16'd0, hsgn | {1'b0, 5'(pos2_r + 5'd15), 10'd0}
                                 | (fsh[15:0] & HALF_FRAC_MASK)};
        end
      end
      REQ_SINGLE_TO_HALF: begin
        hsgn = {op2_r[31], 15'd0};
        if (ef == 8'hff) begin
          res3_nxt.result_bits = {16'd0, hsgn | HALF_INF};
        end else if (ef > 8'd142) begin
          res3_nxt.result_bits = {16'd0, hsgn | HALF_INF};
          res3_nxt.saturated = 1'b1;
        end else if (ef < 8'd113) begin
          if (ef >= 8'd103) begin
            sh = 6'(8'd126 - ef);
            fsh = full >> sh;
            res3_nxt.result_bits = {16'd0, hsgn | (fsh[15:0] & HALF_FRAC_MASK)};
          end else begin
            res3_nxt.result_bits = {16'd0, hsgn};
          end
        end else begin
          res3_nxt.result_bits = {16'd0, hsgn | {1'b0, 5'(ef - EXP_BIAS_DIFF), 10'd0}
                                 | {6'd0, op2_r[22:13]}};
        end
      end
      REQ_HALF_TO_SINGLE: begin
        if (hef == 5'd0) begin
          if (!found2_r) begin
            res3_nxt.result_bits = {op2_r[15], 31'd0};
          end else begin
            fsh = mag2_r << (5'd23 - pos2_r);
            res3_nxt.result_bits = {op2_r[15], 8'({3'd0, pos2_r} + DENORM_BIAS + 8'd13),
                                    fsh[22:0]};
          end
        end else if (hef == HALF_EXP_MAX) begin
          res3_nxt.result_bits = {op2_r[15], 8'hff, op2_r[9:0], 13'd0};
        end else begin
          res3_nxt.result_bits = {op2_r[15], 8'({3'd0, hef} + EXP_BIAS_DIFF),
                                  op2_r[9:0], 13'd0};
        end
      end
      default: res3_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    res3_r <= res3_nxt;
  end

  assign out_valid = v3_r;
  assign out_word = res3_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> ##2 out_valid) else $error("lost word");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v2_r)) else $error("spurious word");
  a_sat_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.saturated) |-> (out_word.result_bits[14:0] == HALF_INF[14:0]))
    else $error("saturation without infinity");
`endif

endmodule
`default_nettype wire

@@ rtl/hpc_lzd.sv @@
// leading-one position of a 32-bit word
`default_nettype none
module hpc_lzd import hpc_pkg::*; (
  input  wire logic [31:0] value,
  output logic             found,
  output logic [4:0]       pos
);
  always_comb begin
    found = 1'b0;
    pos = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (value[i]) begin
        found = 1'b1;
        pos = 5'(i);
      end
    end
  end
endmodule
`default_nettype wire
